[rtl/wavetable_voice_mixer_defines.svh]
// assertion macros for the wavetable voice mixer
`ifndef WAVETABLE_VOICE_MIXER_DEFINES_SVH
`define WAVETABLE_VOICE_MIXER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define WVM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define WVM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/wvm_pkg.sv]
// shared types and constants of the wavetable voice mixer
`default_nettype none
package wvm_pkg;

  localparam int NUM_VOICES = 16;
  localparam int NUM_TABLES = 8;
  localparam int TABLE_SIZE = 1024;
  localparam int OSCS       = 5;
  localparam int OSC_DEPTH  = NUM_VOICES * OSCS;
  localparam int OSC_AW     = $clog2(OSC_DEPTH);
  localparam int WT_DEPTH   = NUM_TABLES * TABLE_SIZE;
  localparam int WT_AW      = $clog2(WT_DEPTH);

  localparam int SPD_W = 26;
  localparam int POS_W = 25;
  localparam int TAB_W = 3;
  localparam int SMP_W = 16;
  localparam int INC_W = 27;
  localparam int VSM_W = 32;
  localparam int SUM_W = 53;
  localparam int NUM_W = 22;
  localparam int CNT_W = 5;

  localparam int MUL_A_W = 42;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int DVD_W   = 23;

  localparam logic [POS_W-1:0] ONE_Q24 = POS_W'(1) << 24;
  localparam logic [15:0]      SAT_MAX = 16'h7fff;
  localparam logic [15:0]      SAT_MIN = 16'h8000;

  // actions
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_PARAM = 2'd1;
  localparam logic [1:0] ACT_TABLE = 2'd2;

  // parameter selects
  localparam logic [4:0] P_ENABLE = 5'd0;
  localparam logic [4:0] P_PAN    = 5'd1;
  localparam logic [4:0] P_SPD0   = 5'd2;
  localparam logic [4:0] P_POS0   = 5'd7;
  localparam logic [4:0] P_TAB0   = 5'd12;
  localparam logic [4:0] P_LAST   = 5'd16;

  // oscillators of a voice
  localparam logic [2:0] OSC_WAVE = 3'd0;
  localparam logic [2:0] OSC_SENV = 3'd1;
  localparam logic [2:0] OSC_SMOD = 3'd2;
  localparam logic [2:0] OSC_AENV = 3'd3;
  localparam logic [2:0] OSC_AMOD = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_VOICE, S_RD, S_UPD, S_TAB, S_MUL, S_MWAIT, S_DIV, S_DWAIT, S_OUT
  } wvm_state_t;

  typedef enum logic [2:0] {
    M_SPD_ENV, M_SPD_MOD, M_AMP_MOD, M_AMP_ENV, M_PAN_L, M_PAN_R
  } wvm_mop_t;

endpackage
`default_nettype wire

[rtl/wvm_serial_mult.sv]
// bit-serial signed multiplier, one multiplier bit per cycle
`default_nettype none
module wvm_serial_mult (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [wvm_pkg::MUL_A_W-1:0]  a,
  input  wire logic signed [wvm_pkg::MUL_B_W-1:0]  b,
  output logic                                     busy,
  output logic                                     done,
  output logic signed [wvm_pkg::MUL_P_W-1:0]       p
);
  import wvm_pkg::*;

  localparam int HI_W = MUL_A_W + 1;
  localparam int CW   = $clog2(MUL_B_W);

  logic signed [HI_W-1:0]    hi_r, hi_nxt;
  logic [MUL_B_W-1:0]        lo_r, lo_nxt;
  logic signed [MUL_A_W-1:0] a_r;
  logic [CW-1:0]             cnt_r;
  logic                      busy_r, done_r;
  logic                      last;
  logic signed [HI_W:0]      addend, tsum;

  always_comb begin
    last   = (cnt_r == CW'(MUL_B_W - 1));
    addend = '0;
    // sign bit of the multiplier carries negative weight
    if (lo_r[0]) begin
      addend = last ? -((HI_W+1)'(a_r)) : (HI_W+1)'(a_r);
    end
    tsum   = (HI_W+1)'(hi_r) + addend;
    hi_nxt = tsum[HI_W:1];
    lo_nxt = {tsum[0], lo_r[MUL_B_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi_r <= '0;
      lo_r <= b;
      a_r  <= a;
    end else if (busy_r) begin
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = {hi_r[MUL_A_W-1:0], lo_r};

endmodule
`default_nettype wire

[rtl/wvm_serial_div.sv]
// bit-serial floor division of a signed sum by the voice count, saturated to q1.15
`default_nettype none
module wvm_serial_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [wvm_pkg::NUM_W-1:0]  num,
  input  wire logic [wvm_pkg::CNT_W-1:0]         den,
  output logic                                   busy,
  output logic                                   done,
  output logic [15:0]                            q
);
  import wvm_pkg::*;

  localparam int CW = $clog2(DVD_W);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [CNT_W-1:0] den_r;
  logic [CNT_W-2:0] rem_r, rem_nxt;
  logic [CW-1:0]    cnt_r;
  logic             neg_r, busy_r, done_r;
  logic [CNT_W-1:0] trial;
  logic             qbit, last;
  logic [DVD_W-1:0] num_ext, start_mag;

  always_comb begin
    last      = (cnt_r == CW'(DVD_W - 1));
    trial     = {rem_r, dvd_r[DVD_W-1]};
    qbit      = (trial >= den_r);
    rem_nxt   = qbit ? (CNT_W-1)'(trial - den_r) : trial[CNT_W-2:0];
    dvd_nxt   = {dvd_r[DVD_W-2:0], qbit};
    num_ext   = DVD_W'(num);
    // negative sums: -num + den - 1 so that the quotient rounds toward minus infinity
    start_mag = num[NUM_W-1] ? (~num_ext + DVD_W'(den)) : num_ext;
  end

  always_comb begin
    if (!neg_r) begin
      q = (dvd_r > DVD_W'(SAT_MAX)) ? SAT_MAX : dvd_r[15:0];
    end else begin
      q = (dvd_r > DVD_W'(SAT_MIN)) ? SAT_MIN : 16'(~dvd_r[15:0] + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= start_mag;
      den_r <= den;
      rem_r <= '0;
      neg_r <= num[NUM_W-1];
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule
`default_nettype wire

[rtl/wavetable_voice_mixer.sv]
// wavetable voice mixer top level: parameter store, voice sequencer and output register
// parameter and table writes are accepted only while the sequencer is idle
// a tick visits the voices one after another, skipping a disabled voice and running
// six serial multiplications for an enabled one
// a frame is presented with both sums divided by the voice count, zeros with no voice enabled
// reset clears enables, pans and all oscillator state; wave table contents stay undefined
`default_nettype none
`include "wavetable_voice_mixer_defines.svh"
module wavetable_voice_mixer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // voice_select, param_select, param_value, table_select, table_address, table_sample
  input  wire logic [71:0] in_tdata,
  // action
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // left_sample, right_sample, active_voices
  output logic [39:0]      out_tdata
);
  import wvm_pkg::*;

  wvm_state_t state_r, state_nxt;
  wvm_mop_t   mop_r;

  // input word fields
  logic               in_acc;
  logic [1:0]         act;
  logic [3:0]         vsel;
  logic [4:0]         psel;
  logic [31:0]        pval;
  logic [2:0]         tsel;
  logic [9:0]         taddr;
  logic [15:0]        tsamp;

  // voice registers
  logic [NUM_VOICES-1:0] en_r;
  logic [15:0]           pan_r [NUM_VOICES];

  // oscillator store
  logic [SPD_W-1:0] spd_mem [OSC_DEPTH];
  logic [POS_W-1:0] pos_mem [OSC_DEPTH];
  logic [TAB_W-1:0] tab_mem [OSC_DEPTH];
  logic [OSC_DEPTH-1:0] spd_vld_r, pos_vld_r, tab_vld_r;
  logic [SPD_W-1:0] spd_q_r;
  logic [POS_W-1:0] pos_q_r;
  logic [TAB_W-1:0] tab_q_r;
  logic             spd_vq_r, pos_vq_r, tab_vq_r;
  logic signed [SPD_W-1:0] spd_rd;
  logic [POS_W-1:0] pos_rd;
  logic [TAB_W-1:0] tab_rd;

  logic [SMP_W-1:0] wt_mem [WT_DEPTH];
  logic [SMP_W-1:0] wt_q_r;
  logic [WT_AW-1:0] wt_raddr;

  // sequencer
  logic [CNT_W-1:0] voice_r, cnt_r;
  logic [2:0]       osc_r;
  logic             side_r;
  logic signed [SMP_W-1:0] rv_r [OSCS];
  logic signed [INC_W-1:0] inc_r;
  logic signed [VSM_W-1:0] smp_r;
  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [SUM_W-1:0] suml_r, sumr_r;
  logic [15:0] left_r, right_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;

  logic [OSC_AW-1:0] osc_addr, par_addr;
  logic [2:0]        par_osc;
  logic              pw, pw_spd, pw_pos, pw_tab;
  logic              osc_rd_en, seq_pos_we, seq_spd_clr, mul_start, div_start;
  logic              spd_we, pos_we;
  logic [OSC_AW-1:0] spd_waddr, pos_waddr;
  logic [SPD_W-1:0]  spd_wdata;
  logic [POS_W-1:0]  pos_wdata;
  logic              voice_en, voices_done, out_free;

  // oscillator update
  logic signed [INC_W-1:0] addend;
  logic signed [INC_W:0]   psum;
  logic                    over, under, is_env;
  logic [POS_W-1:0]        newpos;
  logic [34:0]             idx_prod;

  // arithmetic units
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic                      mul_busy, mul_done;
  logic signed [NUM_W-1:0]   div_num;
  logic [15:0]               div_q;
  logic                      div_busy, div_done;
  logic [16:0]               rf;
  logic [17:0]               lf;

  assign in_acc = in_tvalid && in_tready;
  assign act    = in_tuser;
  assign vsel   = in_tdata[3:0];
  assign psel   = in_tdata[8:4];
  assign pval   = in_tdata[40:9];
  assign tsel   = in_tdata[43:41];
  assign taddr  = in_tdata[53:44];
  assign tsamp  = in_tdata[69:54];

  // parameter write decode
  always_comb begin
    pw     = in_acc && (act == ACT_PARAM);
    pw_spd = pw && (psel >= P_SPD0) && (psel < P_POS0);
    pw_pos = pw && (psel >= P_POS0) && (psel < P_TAB0);
    pw_tab = pw && (psel >= P_TAB0) && (psel <= P_LAST);
    priority if (psel < P_POS0) begin
      par_osc = 3'(psel - P_SPD0);
    end else if (psel < P_TAB0) begin
      par_osc = 3'(psel - P_POS0);
    end else begin
      par_osc = 3'(psel - P_TAB0);
    end
    par_addr = OSC_AW'({vsel, 2'b00}) + OSC_AW'(vsel) + OSC_AW'(par_osc);
    osc_addr = OSC_AW'({voice_r[3:0], 2'b00}) + OSC_AW'(voice_r[3:0]) + OSC_AW'(osc_r);
  end

  assign spd_rd = spd_vq_r ? $signed(spd_q_r) : '0;
  assign pos_rd = pos_vq_r ? pos_q_r : '0;
  assign tab_rd = tab_vq_r ? tab_q_r : '0;

  // position step, then clamp for envelopes or wrap for the rest
  always_comb begin
    addend   = (osc_r == OSC_WAVE) ? inc_r : INC_W'(spd_rd);
    psum     = $signed({3'b000, pos_rd}) + (INC_W+1)'(addend);
    over     = (psum > $signed({3'b000, ONE_Q24}));
    under    = psum[INC_W];
    is_env   = (osc_r == OSC_SENV) || (osc_r == OSC_AENV);
    newpos   = psum[POS_W-1:0];
    if (is_env) begin
      if (over) begin
        newpos = ONE_Q24;
      end else if (under) begin
        newpos = '0;
      end
    end else begin
      if (over) begin
        newpos = {1'b0, psum[23:0]};
      end else if (under) begin
        newpos = (psum[23:0] == 24'd0) ? ONE_Q24 : {1'b0, psum[23:0]};
      end
    end
    idx_prod = {newpos, 10'd0} - {10'd0, newpos};
    wt_raddr = {tab_rd, idx_prod[33:24]};
  end

  // store write ports: parameter writes while idle, sequencer writes while busy
  always_comb begin
    spd_we    = pw_spd || seq_spd_clr;
    spd_waddr = seq_spd_clr ? osc_addr : par_addr;
    spd_wdata = seq_spd_clr ? '0 : pval[SPD_W-1:0];
    pos_we    = pw_pos || seq_pos_we;
    pos_waddr = seq_pos_we ? osc_addr : par_addr;
    pos_wdata = seq_pos_we ? newpos : pval[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (spd_we) begin
      spd_mem[spd_waddr] <= spd_wdata;
    end
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (pw_tab) begin
      tab_mem[par_addr] <= pval[TAB_W-1:0];
    end
    if (osc_rd_en) begin
      spd_q_r  <= spd_mem[osc_addr];
      pos_q_r  <= pos_mem[osc_addr];
      tab_q_r  <= tab_mem[osc_addr];
      spd_vq_r <= spd_vld_r[osc_addr];
      pos_vq_r <= pos_vld_r[osc_addr];
      tab_vq_r <= tab_vld_r[osc_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_vld_r <= '0;
      pos_vld_r <= '0;
      tab_vld_r <= '0;
    end else begin
      if (spd_we) begin
        spd_vld_r[spd_waddr] <= 1'b1;
      end
      if (pos_we) begin
        pos_vld_r[pos_waddr] <= 1'b1;
      end
      if (pw_tab) begin
        tab_vld_r[par_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (act == ACT_TABLE)) begin
      wt_mem[{tsel, taddr}] <= tsamp;
    end
    wt_q_r <= wt_mem[wt_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= '0;
      for (int i = 0; i < NUM_VOICES; i++) begin
        pan_r[i] <= '0;
      end
    end else if (pw && (psel == P_ENABLE)) begin
      en_r[vsel] <= pval[0];
    end else if (pw && (psel == P_PAN)) begin
      pan_r[vsel] <= pval[15:0];
    end
  end

  // multiplier operands
  always_comb begin
    rf = {1'b0, ~pan_r[voice_r[3:0]][15], pan_r[voice_r[3:0]][14:0]};
    lf = 18'h10000 - 18'(rf);
    unique case (mop_r)
      M_SPD_ENV: begin
        mul_a = MUL_A_W'(spd_rd);
        mul_b = MUL_B_W'(rv_r[OSC_SENV]);
      end
      M_SPD_MOD: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(rv_r[OSC_SMOD]);
      end
      M_AMP_MOD: begin
        mul_a = MUL_A_W'(rv_r[OSC_WAVE]);
        mul_b = MUL_B_W'(rv_r[OSC_AMOD]);
      end
      M_AMP_ENV: begin
        mul_a = prod_r[MUL_A_W-1:0];
        mul_b = MUL_B_W'(rv_r[OSC_AENV]);
      end
      M_PAN_L: begin
        mul_a = MUL_A_W'(smp_r);
        mul_b = $signed(lf);
      end
      M_PAN_R: begin
        mul_a = MUL_A_W'(smp_r);
        mul_b = $signed({1'b0, rf});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_num = side_r ? sumr_r[SUM_W-1:31] : suml_r[SUM_W-1:31];

  wvm_serial_mult u_mult (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  wvm_serial_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (cnt_r),
    .busy  (div_busy),
    .done  (div_done),
    .q     (div_q)
  );

  assign voices_done = (voice_r == CNT_W'(NUM_VOICES));
  assign voice_en    = en_r[voice_r[3:0]];
  assign out_free    = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc && (act == ACT_TICK)) state_nxt = S_VOICE;
      S_VOICE: begin
        if (voices_done) begin
          state_nxt = S_DIV;
        end else if (voice_en) begin
          state_nxt = S_RD;
        end
      end
      S_RD:    state_nxt = (osc_r == OSC_WAVE) ? S_MUL : S_UPD;
      S_UPD:   state_nxt = S_TAB;
      S_TAB:   state_nxt = (osc_r == OSC_AMOD || osc_r == OSC_SMOD) ? 
                           ((osc_r == OSC_AMOD) ? S_MUL : S_RD) : S_RD;
      S_MUL:   state_nxt = S_MWAIT;
      S_MWAIT: begin
        if (mul_done) begin
          priority case (mop_r)
            M_SPD_MOD: state_nxt = S_UPD;
            M_PAN_R:   state_nxt = S_VOICE;
            default:   state_nxt = S_MUL;
          endcase
        end
      end
      S_DIV:   state_nxt = (cnt_r == '0) ? S_OUT : S_DWAIT;
      S_DWAIT: if (div_done) state_nxt = side_r ? S_OUT : S_DIV;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready   = 1'b0;
    osc_rd_en   = 1'b0;
    seq_pos_we  = 1'b0;
    seq_spd_clr = 1'b0;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    unique case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_RD:   osc_rd_en = 1'b1;
      S_UPD: begin
        seq_pos_we  = 1'b1;
        seq_spd_clr = is_env && (over || under);
      end
      S_MUL:  mul_start = 1'b1;
      S_DIV:  div_start = (cnt_r != '0);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mop_r       <= M_SPD_ENV;
      voice_r     <= '0;
      cnt_r       <= '0;
      osc_r       <= OSC_SENV;
      side_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          voice_r <= '0;
          cnt_r   <= '0;
          side_r  <= 1'b0;
        end
        S_VOICE: begin
          if (!voices_done) begin
            if (voice_en) begin
              osc_r <= OSC_SENV;
              cnt_r <= cnt_r + CNT_W'(1);
            end else begin
              voice_r <= voice_r + CNT_W'(1);
            end
          end
        end
        S_TAB: begin
          unique case (osc_r)
            OSC_SENV: osc_r <= OSC_SMOD;
            OSC_SMOD: begin
              osc_r <= OSC_WAVE;
              mop_r <= M_SPD_ENV;
            end
            OSC_WAVE: osc_r <= OSC_AENV;
            OSC_AENV: osc_r <= OSC_AMOD;
            default:  mop_r <= M_AMP_MOD;
          endcase
        end
        S_MWAIT: begin
          if (mul_done) begin
            unique case (mop_r)
              M_SPD_ENV: mop_r <= M_SPD_MOD;
              M_AMP_MOD: mop_r <= M_AMP_ENV;
              M_AMP_ENV: mop_r <= M_PAN_L;
              M_PAN_L:   mop_r <= M_PAN_R;
              M_PAN_R:   voice_r <= voice_r + CNT_W'(1);
              default: begin
              end
            endcase
          end
        end
        S_DWAIT: if (div_done) side_r <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // datapath words
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      suml_r <= '0;
      sumr_r <= '0;
    end
    if (state_r == S_TAB) begin
      rv_r[osc_r] <= $signed(wt_q_r);
    end
    if (state_r == S_MWAIT && mul_done) begin
      prod_r <= mul_p;
      unique case (mop_r)
        M_SPD_MOD: inc_r  <= mul_p[56:30];
        M_AMP_ENV: smp_r  <= mul_p[46:15];
        M_PAN_L:   suml_r <= suml_r + mul_p[SUM_W-1:0];
        M_PAN_R:   sumr_r <= sumr_r + mul_p[SUM_W-1:0];
        default: begin
        end
      endcase
    end
    if (state_r == S_DIV && cnt_r == '0) begin
      left_r  <= '0;
      right_r <= '0;
    end
    if (state_r == S_DWAIT && div_done) begin
      if (side_r) begin
        right_r <= div_q;
      end else begin
        left_r <= div_q;
      end
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {3'b000, cnt_r, right_r, left_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `WVM_ASSERT_IMP(a_mul_start_idle, mul_start, !mul_busy, "multiplier started while busy")
  `WVM_ASSERT_IMP(a_div_start_idle, div_start, !div_busy, "divider started while busy")
  `WVM_ASSERT_IMP(a_count_range, state_r != S_IDLE, cnt_r <= CNT_W'(NUM_VOICES), "count overflow")
  `WVM_ASSERT_NXT(a_frame_shown, (state_r == S_OUT) && out_free, out_valid_r, "frame not presented")

endmodule
`default_nettype wire

[tb/testbench.sv]
// self-checking testbench of the wavetable voice mixer: directed and random words, scoreboard
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import wvm_pkg::*;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic [4:0]  count;
  } frame_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  frame_t      frames_due[$];
  int          errors = 0;
  int          snd_idle = 0;
  int          rcv_stall = 0;

  // shadow state of the synthesiser
  logic        sh_en[NUM_VOICES];
  longint      sh_pan[NUM_VOICES];
  longint      sh_spd[OSC_DEPTH];
  longint      sh_pos[OSC_DEPTH];
  int          sh_tab[OSC_DEPTH];
  longint      sh_wt[WT_DEPTH];

  localparam longint UNITY = 64'd1 << 24;

  wavetable_voice_mixer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint table_read(int k);
    longint idx;
    idx = (sh_pos[k] * 1023) >>> 24;
    if (idx > TABLE_SIZE - 1) idx = TABLE_SIZE - 1;
    return sh_wt[(sh_tab[k] % NUM_TABLES) * TABLE_SIZE + idx];
  endfunction

  function automatic void wrap_phase(int k);
    longint p;
    longint f;
    p = sh_pos[k];
    if (p > UNITY) begin
      p = p & (UNITY - 1);
    end else if (p < 0) begin
      f = p & (UNITY - 1);
      p = (f != 0) ? f : UNITY;
    end
    sh_pos[k] = p;
  endfunction

  function automatic void clamp_env(int k);
    if (sh_pos[k] > UNITY) begin
      sh_pos[k] = UNITY;
      sh_spd[k] = 0;
    end else if (sh_pos[k] < 0) begin
      sh_pos[k] = 0;
      sh_spd[k] = 0;
    end
  endfunction

  function automatic longint div_floor(longint x, longint d);
    if (x >= 0) return x / d;
    return -((-x + d - 1) / d);
  endfunction

  function automatic logic [15:0] sat_q15(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // advance every enabled voice by one sample and mix the stereo frame
  function automatic frame_t mix_frame();
    frame_t f;
    longint sum_l, sum_r, cnt, inc, smp, rf, d;
    int     b;
    sum_l = 0;
    sum_r = 0;
    cnt = 0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      if (!sh_en[v]) continue;
      b = v * OSCS;
      cnt++;
      sh_pos[b + 1] += sh_spd[b + 1];
      clamp_env(b + 1);
      sh_pos[b + 2] += sh_spd[b + 2];
      wrap_phase(b + 2);
      inc = (sh_spd[b] * table_read(b + 1) * table_read(b + 2)) >>> 30;
      sh_pos[b] += inc;
      wrap_phase(b);
      sh_pos[b + 3] += sh_spd[b + 3];
      clamp_env(b + 3);
      sh_pos[b + 4] += sh_spd[b + 4];
      wrap_phase(b + 4);
      smp = (table_read(b) * table_read(b + 4) * table_read(b + 3)) >>> 15;
      rf = sh_pan[v] + 32768;
      sum_l += smp * (65536 - rf);
      sum_r += smp * rf;
    end
    f.left = '0;
    f.right = '0;
    if (cnt > 0) begin
      d = cnt * (64'd1 << 31);
      f.left = sat_q15(div_floor(sum_l, d));
      f.right = sat_q15(div_floor(sum_r, d));
    end
    f.count = cnt[4:0];
    return f;
  endfunction

  function automatic void apply_word(logic [1:0] act, logic [3:0] vs, logic [4:0] ps,
                                     logic [31:0] pv, logic [2:0] ts, logic [9:0] ta,
                                     logic [15:0] smp);
    int b;
    b = vs * OSCS;
    if (act == ACT_PARAM && ps <= P_LAST) begin
      if (ps == P_ENABLE) sh_en[vs] = pv[0];
      else if (ps == P_PAN) sh_pan[vs] = longint'($signed(pv[15:0]));
      else if (ps < P_POS0) sh_spd[b + ps - P_SPD0] = longint'($signed(pv[25:0]));
      else if (ps < P_TAB0) sh_pos[b + ps - P_POS0] = longint'(pv[24:0]);
      else sh_tab[b + ps - P_TAB0] = int'(pv[2:0]);
    end else if (act == ACT_TABLE) begin
      sh_wt[ts * TABLE_SIZE + ta] = longint'($signed(smp));
    end else if (act == ACT_TICK) begin
      frames_due.push_back(mix_frame());
    end
  endfunction

  task automatic send_word(logic [1:0] act, logic [3:0] vs, logic [4:0] ps, logic [31:0] pv,
                           logic [2:0] ts, logic [9:0] ta, logic [15:0] smp);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b0, smp, ta, ts, pv, ps, vs};
    do @(posedge clk); while (!in_tready);
    apply_word(act, vs, ps, pv, ts, ta, smp);
  endtask

  task automatic set_param(int v, logic [4:0] ps, logic [31:0] pv);
    send_word(ACT_PARAM, v[3:0], ps, pv, 3'd0, 10'd0, 16'd0);
  endtask

  task automatic tick();
    send_word(ACT_TICK, 4'd0, 5'd0, 32'd0, 3'd0, 10'd0, 16'd0);
  endtask

  // result checker and receiver back-pressure
  always @(posedge clk) begin
    frame_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.left  = out_tdata[15:0];
      got.right = out_tdata[31:16];
      got.count = out_tdata[36:32];
      if (frames_due.size() == 0) begin
        $error("frame with none expected: %h", got);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (got.left !== want.left) begin
          $error("left_sample expected %h got %h", want.left, got.left);
          errors++;
        end
        if (got.right !== want.right) begin
          $error("right_sample expected %h got %h", want.right, got.right);
          errors++;
        end
        if (got.count !== want.count) begin
          $error("active_voices expected %0d got %0d", want.count, got.count);
          errors++;
        end
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rcv_stall);
  end

  // table 0 is filled first and every oscillator select lands on it,
  // so no oscillator ever reads an unwritten entry
  task automatic test_fill_tables();
    for (int a = 0; a < TABLE_SIZE; a++)
      send_word(ACT_TABLE, 4'd0, 5'd0, 32'd0, 3'd0, a[9:0], 16'($urandom));
  endtask

  task automatic test_directed();
    tick();                                              // no voice enabled
    send_word(ACT_TABLE, 4'd0, 5'd0, 32'd0, 3'd7, 10'd1023, 16'h7fff);
    send_word(ACT_TABLE, 4'd0, 5'd0, 32'd0, 3'd0, 10'd0, 16'h8000);
    set_param(0, P_ENABLE, 32'hffff_ffff);
    set_param(15, P_ENABLE, 32'd1);
    set_param(0, P_PAN, 32'h0000_8000);                  // hard left
    set_param(15, P_PAN, 32'h7fff_7fff);                 // hard right
    set_param(0, P_SPD0, 32'h01ff_ffff);                 // biggest positive speed
    set_param(0, P_SPD0 + 1, 32'hff00_0000);             // envelope falls below zero
    set_param(0, P_SPD0 + 2, 32'h0200_0000);             // most negative speed
    set_param(0, P_POS0 + 2, 32'd0);                     // negative whole number wraps to one
    set_param(15, P_POS0, 32'hffff_ffff);                // beyond one before the first wrap
    set_param(15, P_POS0 + 3, 32'h0100_0000);            // envelope at exactly one
    set_param(15, P_SPD0 + 3, 32'h0000_1000);            // and pushed above it
    set_param(15, P_TAB0, 32'hffff_fff8);                // upper bits of the select dropped
    set_param(15, P_TAB0 + 4, 32'd8);
    set_param(3, 5'd17, 32'hffff_ffff);                  // parameter select out of range
    set_param(3, 5'd31, 32'hffff_ffff);
    send_word(2'd3, 4'd3, P_ENABLE, 32'd1, 3'd0, 10'd0, 16'd0);  // unused action
    tick();
    tick();
    tick();
    set_param(0, P_ENABLE, 32'd0);
    tick();
  endtask

  task automatic test_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        tick();
      end else if (r < 82) begin
        logic [31:0] pv;
        logic [4:0]  ps;
        ps = 5'($urandom_range(0, 16));
        pv = $urandom;
        // mostly audible speeds, sometimes the full range
        if (ps >= P_SPD0 && ps < P_POS0 && $urandom_range(0, 3) != 0)
          pv = 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        else if (ps >= P_POS0 && ps < P_TAB0 && $urandom_range(0, 1) != 0)
          pv = $urandom_range(0, 32'h0100_0000);
        else if (ps == P_ENABLE && $urandom_range(0, 2) == 0)
          pv[0] = 1'b0;
        else if (ps >= P_TAB0)
          pv[2:0] = 3'd0;
        set_param($urandom_range(0, NUM_VOICES - 1), ps, pv);
      end else if (r < 94) begin
        send_word(ACT_TABLE, 4'($urandom), 5'($urandom), $urandom, 3'($urandom),
                  10'($urandom), 16'($urandom));
      end else if (r < 97) begin
        set_param($urandom_range(0, NUM_VOICES - 1), 5'($urandom_range(17, 31)), $urandom);
      end else begin
        send_word(2'd3, 4'($urandom), 5'($urandom), $urandom, 3'($urandom),
                  10'($urandom), 16'($urandom));
      end
    end
  endtask

  // sender holds off until the mixer has delivered every frame
  task automatic test_drain_pause();
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    tick();
    tick();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = ACT_TICK;
    out_tready = 1'b0;
    for (int i = 0; i < NUM_VOICES; i++) begin
      sh_en[i] = 1'b0;
      sh_pan[i] = 0;
    end
    for (int i = 0; i < OSC_DEPTH; i++) begin
      sh_spd[i] = 0;
      sh_pos[i] = 0;
      sh_tab[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fill_tables();
    test_directed();
    test_random(90);
    snd_idle = 69;
    test_random(90);
    test_drain_pause();
    snd_idle = 0;
    rcv_stall = 69;
    test_random(90);
    snd_idle = 32;
    rcv_stall = 32;
    test_random(90);
    in_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("[wavetable_voice_mixer] OK");
    else
      $display("[wavetable_voice_mixer] ERROR");
    $finish;
  end

  initial begin
    #400ms;
    $display("[wavetable_voice_mixer] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
